// File: hw/rtl/longest_nested_interval_chain_macros.svh
// Assertion macros for the nested interval chain block
`ifndef LONGEST_NESTED_INTERVAL_CHAIN_MACROS_SVH
`define LONGEST_NESTED_INTERVAL_CHAIN_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LNIC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LNIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LNIC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define LNIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/lnic_pkg.sv
// ----------------------------------------------------------------------------
// lnic_pkg
// Shared constants and types of the nested interval chain block.
// ----------------------------------------------------------------------------
package lnic_pkg;
    localparam int MAX_INTERVALS = 2048;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int CHAIN_W       = 12;
    localparam int COORD_W       = 16;
    localparam logic [CHAIN_W-1:0] CHAIN_MAX = '1;

    typedef struct packed {
        logic [COORD_W-1:0] s;
        logic [COORD_W-1:0] e;
    } t_ival;
endpackage

// File: hw/rtl/lnic_ram.sv
// ----------------------------------------------------------------------------
// lnic_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lnic_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/longest_nested_interval_chain.sv
// Loading: one interval per cycle while o_in_stall is low; still ready after each request but the last.
// Last request starts ranking by length (each interval compared against all n
// stored intervals) and then the chain pass (n intervals, each compared against
// those sorted before it), then the result waits until taken.
// Synchronous active-low reset empties the set; the stores are not cleared.
// ----------------------------------------------------------------------------
// longest_nested_interval_chain
// Collects intervals, sorts them by length via rank counting and runs the
// nested-chain dynamic program over stored entries with one compare unit.
// ----------------------------------------------------------------------------
`include "longest_nested_interval_chain_macros.svh"

module longest_nested_interval_chain import lnic_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [COORD_W-1:0] i_interval_start,
    input  logic [COORD_W-1:0] i_interval_end,
    input  logic               i_last_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [CHAIN_W-1:0] o_chain_length,
    output logic               o_overflow_flag,
    output logic               o_bad_interval_flag
);
    typedef enum logic [3:0] {
        S_LOAD, S_RANK_I, S_RANK_IL, S_RANK_J, S_RANK_JU, S_RANK_W,
        S_DP_I, S_DP_IL, S_DP_J, S_DP_JU, S_DP_W, S_OUT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count, r_n, r_i, r_j, r_rank;
    logic               r_ovf, r_bad;
    t_ival              r_cur;
    logic [CHAIN_W-1:0] r_c, r_best;

    logic               in_acc, bad, room;
    t_ival              in_ival, raw_rd, srt_rd;
    logic [CHAIN_W-1:0] chn_rd, cand;
    logic [CNT_W-1:0]   n_count, i_inc, j_inc;
    logic [COORD_W-1:0] len_cur, len_j;
    logic               rank_hit, nest_hit;

    assign o_in_stall = (r_state != S_LOAD);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign bad        = i_interval_start > i_interval_end;
    assign room       = r_count < CNT_W'(MAX_INTERVALS);
    assign in_ival    = '{s: i_interval_start, e: i_interval_end};
    assign n_count    = (!bad && room) ? CNT_W'(r_count + 1'b1) : r_count;
    assign i_inc      = CNT_W'(r_i + 1'b1);
    assign j_inc      = CNT_W'(r_j + 1'b1);

    lnic_ram #(.W($bits(t_ival)), .D(MAX_INTERVALS)) u_raw (
        .i_clk  (i_clk),
        .i_we   (in_acc && !bad && room),
        .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(in_ival),
        .i_raddr((r_state == S_RANK_I) ? r_i[IDX_W-1:0] : r_j[IDX_W-1:0]),
        .o_rdata(raw_rd)
    );

    lnic_ram #(.W($bits(t_ival)), .D(MAX_INTERVALS)) u_sorted (
        .i_clk  (i_clk),
        .i_we   (r_state == S_RANK_W),
        .i_waddr(r_rank[IDX_W-1:0]),
        .i_wdata(r_cur),
        .i_raddr((r_state == S_DP_I) ? r_i[IDX_W-1:0] : r_j[IDX_W-1:0]),
        .o_rdata(srt_rd)
    );

    lnic_ram #(.W(CHAIN_W), .D(MAX_INTERVALS)) u_chain (
        .i_clk  (i_clk),
        .i_we   (r_state == S_DP_W),
        .i_waddr(r_i[IDX_W-1:0]),
        .i_wdata(r_c),
        .i_raddr(r_j[IDX_W-1:0]),
        .o_rdata(chn_rd)
    );

    // stable order: shorter first, ties by arrival
    assign len_cur  = r_cur.e - r_cur.s;
    assign len_j    = raw_rd.e - raw_rd.s;
    assign rank_hit = (len_j < len_cur) || ((len_j == len_cur) && (r_j < r_i));
    assign cand     = (chn_rd == CHAIN_MAX) ? CHAIN_MAX : CHAIN_W'(chn_rd + 1'b1);
    assign nest_hit = (r_cur.s <= srt_rd.s) && (r_cur.e >= srt_rd.e) && (cand > r_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_bad   <= 1'b0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_best  <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_count <= n_count;
                        r_bad   <= r_bad | bad;
                        r_ovf   <= r_ovf | (!bad && !room);
                        if (i_last_item) begin
                            r_n    <= n_count;
                            r_i    <= '0;
                            r_best <= '0;
                            r_state <= (n_count == '0) ? S_OUT : S_RANK_I;
                        end
                    end
                end
                S_RANK_I:  r_state <= S_RANK_IL;
                S_RANK_IL: begin
                    r_cur   <= raw_rd;
                    r_j     <= '0;
                    r_rank  <= '0;
                    r_state <= S_RANK_J;
                end
                S_RANK_J:  r_state <= S_RANK_JU;
                S_RANK_JU: begin
                    if (rank_hit) begin
                        r_rank <= CNT_W'(r_rank + 1'b1);
                    end
                    r_j     <= j_inc;
                    r_state <= (j_inc == r_n) ? S_RANK_W : S_RANK_J;
                end
                S_RANK_W: begin
                    r_i     <= (i_inc == r_n) ? '0 : i_inc;
                    r_state <= (i_inc == r_n) ? S_DP_I : S_RANK_I;
                end
                S_DP_I:  r_state <= S_DP_IL;
                S_DP_IL: begin
                    r_cur   <= srt_rd;
                    r_c     <= CHAIN_W'(1);
                    r_j     <= '0;
                    r_state <= (r_i == '0) ? S_DP_W : S_DP_J;
                end
                S_DP_J:  r_state <= S_DP_JU;
                S_DP_JU: begin
                    if (nest_hit) begin
                        r_c <= cand;
                    end
                    r_j     <= j_inc;
                    r_state <= (j_inc == r_i) ? S_DP_W : S_DP_J;
                end
                S_DP_W: begin
                    if (r_c > r_best) begin
                        r_best <= r_c;
                    end
                    r_i     <= i_inc;
                    r_state <= (i_inc == r_n) ? S_OUT : S_DP_I;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_bad   <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_out_valid         = (r_state == S_OUT);
    assign o_chain_length      = r_best;
    assign o_overflow_flag     = r_ovf;
    assign o_bad_interval_flag = r_bad;

    `LNIC_ASSERT_NEXT(a_clear_after_out, i_clk, i_rst_n,
        o_out_valid && !i_out_stall, r_count == '0 && !r_ovf && !r_bad)
    `LNIC_ASSERT_NEXT(a_last_starts_work, i_clk, i_rst_n,
        in_acc && i_last_item, r_state != S_LOAD)
    `LNIC_ASSERT_SAME(a_index_in_set, i_clk, i_rst_n,
        r_state != S_LOAD && r_state != S_OUT, r_i < r_n)
    `LNIC_ASSERT_SAME(a_best_bounded, i_clk, i_rst_n,
        o_out_valid, r_best <= CHAIN_W'(r_n))
endmodule
